FILE: rtl/dltq_pkg.sv
// Shared types and constants of the delta-list timeout queue.
package dltq_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int RESULT_CAP  = 32;
   localparam int N_W         = $clog2(RESULT_CAP + 1);

   localparam logic [1:0] MODE_INSERT  = 2'd0;
   localparam logic [1:0] MODE_REMOVE  = 2'd1;
   localparam logic [1:0] MODE_TICK    = 2'd2;
   localparam logic [1:0] MODE_IGNORED = 2'd3;

   localparam logic [2:0] EV_TIMEOUT  = 3'd0;
   localparam logic [2:0] EV_REMOVED  = 3'd1;
   localparam logic [2:0] EV_INSERTED = 3'd2;
   localparam logic [2:0] EV_FULL     = 3'd3;
   localparam logic [2:0] EV_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [15:0] delta;
      logic [7:0]  waiter;
      logic [5:0]  sema;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD    = 2'd0,
      CELL_LOAD    = 2'd1,
      CELL_FROM_LO = 2'd2,
      CELL_FROM_HI = 2'd3
   } cell_cmd_type;

endpackage

FILE: rtl/delta_list_timeout_queue.sv
// Top level: delta-list timeout queue built as a chain of list cells.
//
// Usage: drive req_mode, req_waiter_id, req_sema_id and req_timeout with start;
// the word is taken at a clock edge where start is high and busy is low.
// Modes: insert, remove, tick. Results come out on rsp_* for one cycle each,
// marked by rsp_valid; rsp_last flags the final result of a request.
// Insert: walks the list one cell per cycle to find its place, then shifts
// the cells and fixes the next delta if there is one; one result.
// A full list answers without a walk, with a full result. Remove: searches
// one cell per cycle, merges the delta into the successor if there is one
// and shifts; one result, also when not found. Tick: decrements a non-zero
// head delta, then emits one expired head per cycle, up to 32 results in
// consecutive cycles; a tick with nothing expired gives no result.
// Reset empties the list and clears the result strobe; cell contents are
// not cleared. The receiver cannot stall: each result is taken as it shows.
module delta_list_timeout_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_waiter_id,
   input  logic [5:0]  req_sema_id,
   input  logic [15:0] req_timeout,
   output logic        rsp_valid,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_out_waiter,
   output logic [5:0]  rsp_out_sema,
   output logic        rsp_last
);

   localparam int D  = dltq_pkg::QUEUE_DEPTH;
   localparam int IW = dltq_pkg::IDX_W;
   localparam int CW = dltq_pkg::CNT_W;
   localparam int NW = dltq_pkg::N_W;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_INS_WALK  = 7'b0000010,
      ST_INS_FIX   = 7'b0000100,
      ST_REM_WALK  = 7'b0001000,
      ST_REM_MERGE = 7'b0010000,
      ST_REM_SHIFT = 7'b0100000,
      ST_TICK_EMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [15:0]   before_ff, before_in;
   logic [15:0]   nd_ff, nd_in;
   logic [NW-1:0] n_ff, n_in;
   logic [7:0]    wid_ff, wid_in;
   logic [5:0]    sid_ff, sid_in;
   logic [15:0]   tmo_ff, tmo_in;
   logic [5:0]    hit_sema_ff, hit_sema_in;

   logic          rv_ff, rv_in;
   logic [2:0]    rev_ff, rev_in;
   logic [7:0]    rw_ff, rw_in;
   logic [5:0]    rs_ff, rs_in;
   logic          rl_ff, rl_in;

   dltq_pkg::entry_type    cells [D];
   dltq_pkg::cell_cmd_type cmds [D];
   dltq_pkg::entry_type    load_bus;

   logic [IW-1:0] pidx, pidx1;
   dltq_pkg::entry_type cur, nxt;
   logic [16:0]   walk_sum, merge_sum;
   logic [CW:0]   pos_p1;

   assign pidx   = pos_ff[IW-1:0];
   assign pos_p1 = {1'b0, pos_ff} + (CW+1)'(1);
   assign pidx1  = pos_p1[IW-1:0];
   assign cur    = cells[pidx];
   assign nxt    = cells[pidx1];
   assign walk_sum  = {1'b0, before_ff} + {1'b0, cur.delta};
   assign merge_sum = {1'b0, cur.delta} + {1'b0, nxt.delta};

   genvar g;
   generate
      for (g = 0; g < D; g++) begin : g_cell
         dltq_cell u_cell (
            .clock      (clock),
            .cmd        (cmds[g]),
            .lo_entry   ((g == 0) ? load_bus : cells[(g == 0) ? 0 : g - 1]),
            .hi_entry   ((g == D - 1) ? load_bus : cells[(g == D - 1) ? g : g + 1]),
            .load_entry (load_bus),
            .entry      (cells[g])
         );
      end
   endgenerate

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      before_in   = before_ff;
      nd_in       = nd_ff;
      n_in        = n_ff;
      wid_in      = wid_ff;
      sid_in      = sid_ff;
      tmo_in      = tmo_ff;
      hit_sema_in = hit_sema_ff;
      rv_in       = 1'b0;
      rev_in      = rev_ff;
      rw_in       = rw_ff;
      rs_in       = rs_ff;
      rl_in       = 1'b1;
      load_bus    = cur;
      for (int i = 0; i < D; i++) begin
         cmds[i] = dltq_pkg::CELL_HOLD;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               wid_in    = req_waiter_id;
               sid_in    = req_sema_id;
               tmo_in    = req_timeout;
               pos_in    = '0;
               before_in = '0;
               n_in      = '0;
               case (req_mode)
                  dltq_pkg::MODE_INSERT: begin
                     if (count_ff == CW'(D)) begin
                        rv_in  = 1'b1;
                        rev_in = dltq_pkg::EV_FULL;
                        rw_in  = req_waiter_id;
                        rs_in  = req_sema_id;
                     end else begin
                        state_in = ST_INS_WALK;
                     end
                  end
                  dltq_pkg::MODE_REMOVE: begin
                     state_in = ST_REM_WALK;
                  end
                  dltq_pkg::MODE_TICK: begin
                     if (count_ff != '0) begin
                        if (cells[0].delta != '0) begin
                           load_bus       = cells[0];
                           load_bus.delta = cells[0].delta - 16'd1;
                           cmds[0]        = dltq_pkg::CELL_LOAD;
                        end
                        state_in = ST_TICK_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_INS_WALK: begin
            if (pos_ff < count_ff && walk_sum <= {1'b0, tmo_ff}) begin
               before_in = walk_sum[15:0];
               pos_in    = pos_ff + CW'(1);
            end else begin
               nd_in          = tmo_ff - before_ff;
               load_bus.delta  = tmo_ff - before_ff;
               load_bus.waiter = wid_ff;
               load_bus.sema   = sid_ff;
               for (int i = 0; i < D; i++) begin
                  if (CW'(i) == pos_ff) begin
                     cmds[i] = dltq_pkg::CELL_LOAD;
                  end else if (CW'(i) > pos_ff) begin
                     cmds[i] = dltq_pkg::CELL_FROM_LO;
                  end
               end
               count_in = count_ff + CW'(1);
               if (pos_ff < count_ff) begin
                  state_in = ST_INS_FIX;
               end else begin
                  rv_in    = 1'b1;
                  rev_in   = dltq_pkg::EV_INSERTED;
                  rw_in    = wid_ff;
                  rs_in    = sid_ff;
                  state_in = ST_IDLE;
               end
            end
         end

         ST_INS_FIX: begin
            load_bus       = nxt;
            load_bus.delta = nxt.delta - nd_ff;
            for (int i = 0; i < D; i++) begin
               if (IW'(i) == pidx1) begin
                  cmds[i] = dltq_pkg::CELL_LOAD;
               end
            end
            rv_in    = 1'b1;
            rev_in   = dltq_pkg::EV_INSERTED;
            rw_in    = wid_ff;
            rs_in    = sid_ff;
            state_in = ST_IDLE;
         end

         ST_REM_WALK: begin
            if (pos_ff == count_ff) begin
               rv_in    = 1'b1;
               rev_in   = dltq_pkg::EV_NOTFOUND;
               rw_in    = wid_ff;
               rs_in    = '0;
               state_in = ST_IDLE;
            end else if (cur.waiter == wid_ff) begin
               hit_sema_in = cur.sema;
               if (pos_p1 < {1'b0, count_ff}) begin
                  state_in = ST_REM_MERGE;
               end else begin
                  state_in = ST_REM_SHIFT;
               end
            end else begin
               pos_in = pos_ff + CW'(1);
            end
         end

         ST_REM_MERGE: begin
            load_bus       = nxt;
            load_bus.delta = merge_sum[16] ? 16'hFFFF : merge_sum[15:0];
            for (int i = 0; i < D; i++) begin
               if (IW'(i) == pidx1) begin
                  cmds[i] = dltq_pkg::CELL_LOAD;
               end
            end
            state_in = ST_REM_SHIFT;
         end

         ST_REM_SHIFT: begin
            for (int i = 0; i < D; i++) begin
               if (CW'(i) >= pos_ff) begin
                  cmds[i] = dltq_pkg::CELL_FROM_HI;
               end
            end
            count_in = count_ff - CW'(1);
            rv_in    = 1'b1;
            rev_in   = dltq_pkg::EV_REMOVED;
            rw_in    = wid_ff;
            rs_in    = hit_sema_ff;
            state_in = ST_IDLE;
         end

         ST_TICK_EMIT: begin
            if (count_ff != '0 && cells[0].delta == '0
                && n_ff < NW'(dltq_pkg::RESULT_CAP)) begin
               for (int i = 0; i < D; i++) begin
                  cmds[i] = dltq_pkg::CELL_FROM_HI;
               end
               count_in = count_ff - CW'(1);
               n_in     = n_ff + NW'(1);
               rv_in    = 1'b1;
               rev_in   = dltq_pkg::EV_TIMEOUT;
               rw_in    = cells[0].waiter;
               rs_in    = cells[0].sema;
               rl_in    = !(count_ff > CW'(1) && cells[1].delta == '0
                            && n_ff < NW'(dltq_pkg::RESULT_CAP - 1));
               if (rl_in) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      pos_ff      <= pos_in;
      before_ff   <= before_in;
      nd_ff       <= nd_in;
      n_ff        <= n_in;
      wid_ff      <= wid_in;
      sid_ff      <= sid_in;
      tmo_ff      <= tmo_in;
      hit_sema_ff <= hit_sema_in;
      rev_ff      <= rev_in;
      rw_ff       <= rw_in;
      rs_ff       <= rs_in;
      rl_ff       <= rl_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rv_ff;
   assign rsp_event_res  = rev_ff;
   assign rsp_out_waiter = rw_ff;
   assign rsp_out_sema   = rs_ff;
   assign rsp_last       = rl_ff;

endmodule

FILE: rtl/dltq_cell.sv
// One list position: holds an entry, loads it or takes a neighbor's word.
module dltq_cell (
   input  logic                  clock,
   input  dltq_pkg::cell_cmd_type cmd,
   input  dltq_pkg::entry_type   lo_entry,
   input  dltq_pkg::entry_type   hi_entry,
   input  dltq_pkg::entry_type   load_entry,
   output dltq_pkg::entry_type   entry
);

   dltq_pkg::entry_type entry_ff;
   dltq_pkg::entry_type entry_in;

   always_comb begin
      case (cmd)
         dltq_pkg::CELL_LOAD:    entry_in = load_entry;
         dltq_pkg::CELL_FROM_LO: entry_in = lo_entry;
         dltq_pkg::CELL_FROM_HI: entry_in = hi_entry;
         default:                entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/dltq_checker.sv
// Port-level checks of the timeout queue and their bind to the top level.
module dltq_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic [2:0]  rsp_event_res,
   input logic [5:0]  rsp_out_sema,
   input logic        rsp_last
);

   a_mode3_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode == dltq_pkg::MODE_IGNORED |=> !rsp_valid)
      else $error("unused mode produced a result");

   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside a timeout burst");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != dltq_pkg::EV_TIMEOUT |-> rsp_last)
      else $error("non-timeout result not final");

   a_notfound_sema: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == dltq_pkg::EV_NOTFOUND |-> rsp_out_sema == 6'd0)
      else $error("not-found result carries a semaphore");

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_res <= dltq_pkg::EV_NOTFOUND)
      else $error("event code out of range");

endmodule

bind delta_list_timeout_queue dltq_checker u_dltq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_mode      (req_mode),
   .rsp_valid     (rsp_valid),
   .rsp_event_res (rsp_event_res),
   .rsp_out_sema  (rsp_out_sema),
   .rsp_last      (rsp_last)
);
